// ----- sv/utf8v_pkg.sv -----
// ============================================================================
// utf8v_pkg
// Shared widths and code point limits for the UTF-8 stream validator.
// ============================================================================
package utf8v_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned CpW   = 21;
    localparam int unsigned CntW  = 2;

    // Code point limits used when a multi-byte sequence completes
    localparam logic [CpW-1:0] CpMinTwo    = 21'h000080;
    localparam logic [CpW-1:0] CpMinThree  = 21'h000800;
    localparam logic [CpW-1:0] CpSurrLo    = 21'h00D800;
    localparam logic [CpW-1:0] CpSurrHi    = 21'h00DFFF;
    localparam logic [CpW-1:0] CpNoncharA  = 21'h00FFFE;
    localparam logic [CpW-1:0] CpNoncharB  = 21'h00FFFF;
    localparam logic [CpW-1:0] CpMinFour   = 21'h010000;
    localparam logic [CpW-1:0] CpMaxFour   = 21'h10FFFF;

    // Sequence lengths, counted in continuation bytes
    localparam logic [CntW-1:0] SeqNone  = 2'd0;
    localparam logic [CntW-1:0] SeqTwo   = 2'd1;
    localparam logic [CntW-1:0] SeqThree = 2'd2;
    localparam logic [CntW-1:0] SeqFour  = 2'd3;

    // True if a completed sequence decodes to an allowed code point
    function automatic logic code_ok(input logic [CntW-1:0] len,
                                     input logic [CpW-1:0]  cp);
        logic ok;
        begin
            case (len)
                SeqTwo: begin
                    ok = (cp >= CpMinTwo);
                end
                SeqThree: begin
                    ok = (cp >= CpMinThree)
                        && !((cp >= CpSurrLo) && (cp <= CpSurrHi))
                        && (cp != CpNoncharA) && (cp != CpNoncharB);
                end
                default: begin
                    ok = (cp >= CpMinFour) && (cp <= CpMaxFour);
                end
            endcase
            return ok;
        end
    endfunction

endpackage

// ----- sv/utf8_stream_validator_unit.sv -----
// ============================================================================
// utf8_stream_validator_unit
// Streaming UTF-8 checker: one byte per transaction, one verdict per string.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one byte of a string per
//   transaction, with i_last_byte set on the final byte. Output channel
//   (o_out_valid / i_out_stall) carries exactly one verdict per string,
//   o_is_valid = 1 for well-formed UTF-8, produced by the final byte.
//   Bytes that are not final produce no output transaction.
//   Pipeline: input register -> checker logic -> verdict register.
//   The verdict register loads as the final byte leaves the input register.
//   Throughput: one byte per cycle while no final byte waits on a stalled
//   verdict, set by the combinational decode between the two registers.
//   A zero byte at a lead position ends the string as valid; later bytes up
//   to the final one are skipped. After the first fault the rest of the
//   string is skipped and the verdict is 0. A sequence cut short by the
//   final byte is invalid.
//   Reset (synchronous, active low) empties both registers and clears the
//   decode state, so the next byte starts a new string.
//   Output stall: the verdict holds in its register; non-final bytes keep
//   flowing. A final byte waits in the input register only while a previous
//   verdict is still stalled, and then o_in_stall is raised.
// ============================================================================
module utf8_stream_validator_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [utf8v_pkg::ByteW-1:0]     i_byte_value,
    input  logic                            i_last_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_is_valid
);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    // input stage
    logic                               r_in_valid;
    logic [utf8v_pkg::ByteW-1:0]        r_byte;
    logic                               r_last;
    // decode state for the string in progress
    logic [utf8v_pkg::CntW-1:0]         r_pend;     // continuation bytes still due
    logic [utf8v_pkg::CntW-1:0]         r_seq;      // length of current sequence
    logic [utf8v_pkg::CpW-1:0]          r_acc;      // code point bits so far
    logic                               r_fault;
    logic                               r_term;
    // verdict stage
    logic                               r_out_valid;
    logic                               r_is_valid;

    logic [utf8v_pkg::CntW-1:0]         n_pend;
    logic [utf8v_pkg::CntW-1:0]         n_seq;
    logic [utf8v_pkg::CpW-1:0]          n_acc;
    logic                               n_fault;
    logic                               n_term;
    logic                               n_verdict;

    logic                               out_free;   // verdict register can load
    logic                               s1_fire;    // input stage item processed
    logic                               in_take;    // input transaction accepted
    logic [utf8v_pkg::CpW-1:0]          cont_acc;   // accumulator after this byte

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    // Only a final byte needs room in the verdict register.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_fire    = r_in_valid && (!r_last || out_free);
    assign o_in_stall = r_in_valid && !s1_fire;
    assign in_take    = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_is_valid  = r_is_valid;

    assign cont_acc = {r_acc[utf8v_pkg::CpW-7:0], r_byte[5:0]};

    // ------------------------------------------------------------------
    // Per-byte decode
    // ------------------------------------------------------------------
    always_comb begin
        n_pend  = r_pend;
        n_seq   = r_seq;
        n_acc   = r_acc;
        n_fault = r_fault;
        n_term  = r_term;

        if (!r_fault && !r_term) begin
            if (r_pend != utf8v_pkg::SeqNone) begin
                // continuation position: must be 10xxxxxx
                if (r_byte[7:6] != 2'b10) begin
                    n_fault = 1'b1;
                end else begin
                    n_pend = r_pend - 2'd1;
                    n_acc  = cont_acc;
                    if (r_pend == 2'd1) begin
                        if (!utf8v_pkg::code_ok(r_seq, cont_acc)) begin
                            n_fault = 1'b1;
                        end
                        n_seq = utf8v_pkg::SeqNone;
                        n_acc = '0;
                    end
                end
            end else if (r_byte == '0) begin
                n_term = 1'b1;
            end else if (!r_byte[7]) begin
                // plain ASCII, nothing to track
            end else if ((r_byte[7:6] == 2'b10) || (r_byte[7:3] == 5'b11111)) begin
                n_fault = 1'b1;
            end else if (r_byte[7:5] == 3'b110) begin
                n_seq  = utf8v_pkg::SeqTwo;
                n_pend = utf8v_pkg::SeqTwo;
                n_acc  = {{(utf8v_pkg::CpW-5){1'b0}}, r_byte[4:0]};
            end else if (r_byte[7:4] == 4'b1110) begin
                n_seq  = utf8v_pkg::SeqThree;
                n_pend = utf8v_pkg::SeqThree;
                n_acc  = {{(utf8v_pkg::CpW-4){1'b0}}, r_byte[3:0]};
            end else begin
                n_seq  = utf8v_pkg::SeqFour;
                n_pend = utf8v_pkg::SeqFour;
                n_acc  = {{(utf8v_pkg::CpW-3){1'b0}}, r_byte[2:0]};
            end
        end

        // fault wins over terminator; otherwise no sequence may be left open
        n_verdict = !n_fault && (n_term || (n_pend == utf8v_pkg::SeqNone));
    end

    // ------------------------------------------------------------------
    // Sequential
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_pend      <= utf8v_pkg::SeqNone;
            r_seq       <= utf8v_pkg::SeqNone;
            r_acc       <= '0;
            r_fault     <= 1'b0;
            r_term      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // input register
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (s1_fire) begin
                r_in_valid <= 1'b0;
            end

            // decode state; a final byte clears it for the next string
            if (s1_fire) begin
                if (r_last) begin
                    r_pend  <= utf8v_pkg::SeqNone;
                    r_seq   <= utf8v_pkg::SeqNone;
                    r_acc   <= '0;
                    r_fault <= 1'b0;
                    r_term  <= 1'b0;
                end else begin
                    r_pend  <= n_pend;
                    r_seq   <= n_seq;
                    r_acc   <= n_acc;
                    r_fault <= n_fault;
                    r_term  <= n_term;
                end
            end

            // verdict register
            if (s1_fire && r_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_byte <= i_byte_value;
            r_last <= i_last_byte;
        end
        if (s1_fire && r_last) begin
            r_is_valid <= n_verdict;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_pend_le_seq : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= r_seq)
        else $error("pending count exceeds sequence length");

    a_seq_idle_match : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == utf8v_pkg::SeqNone) == (r_pend == utf8v_pkg::SeqNone))
        else $error("sequence length and pending count disagree");

    a_fault_term_excl : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_fault && r_term))
        else $error("fault and terminator both set");

    a_clear_after_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_last) |=> (r_pend == utf8v_pkg::SeqNone) && !r_fault && !r_term
                                && r_out_valid)
        else $error("state not cleared or verdict missing after final byte");

    a_nonlast_no_verdict : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && !r_last && !r_out_valid) |=> !r_out_valid)
        else $error("verdict produced by a non-final byte");

endmodule
